>>> rtl/core/vertex_normal_averager_assert.svh
// assertion macros for the vertex normal averager
`ifndef VERTEX_NORMAL_AVERAGER_ASSERT_SVH
`define VERTEX_NORMAL_AVERAGER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define VNA_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vertex normal averager check failed");

// next-cycle implication, checked out of reset
`define VNA_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vertex normal averager check failed");

`endif

>>> rtl/core/vna_pkg.sv
package vna_pkg;

    // default mesh size
    localparam int NUM_VERTICES_DEF = 64;

    // field widths
    localparam int IDX_W  = 6;
    localparam int POS_W  = 16;
    localparam int SUM_W  = 24;
    localparam int NORM_W = 16;
    localparam int MAG_W  = 36;

    // op codes
    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_TRI  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    // fixed-point limits
    localparam logic [15:0] ONE_Q14 = 16'd16384;
    localparam logic signed [24:0] SUM_MAX = 25'sd8388607;
    localparam logic signed [24:0] SUM_MIN = -25'sd8388608;

endpackage

>>> rtl/core/vna_ram.sv
module vna_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/vertex_normal_averager.sv
// Smoothed per-vertex normals. A load request (op 0) stores a Q7.8 position and
// clears that vertex's sum. A triangle request (op 1) reads the three corners,
// forms the edge cross product on one shared multiplier, normalizes it to a Q1.14
// unit vector and adds it with saturation to each corner's sum. A read request
// (op 2) normalizes the stored sum and returns it through the output register,
// waiting while that register still holds a result not yet taken. Op 3 and
// requests with an out-of-range index (idx_a at or above NUM_VERTICES, or for
// op 1 also idx_b or idx_c) do nothing. The time is set by the 25-step
// bit-serial square root, the three 16-step dividers and the prescale shifter
// (8 or 1 bit a cycle). One request is worked on at a time; a waiting result
// holds off only a later read, which then waits before its own result is loaded.
// After reset a clearing pass zeroes every sum entry, taking no request meanwhile.
`include "vertex_normal_averager_assert.svh"

module vertex_normal_averager #(
    parameter int NUM_VERTICES = vna_pkg::NUM_VERTICES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         op,
    input  logic [5:0]         idx_a,
    input  logic [5:0]         idx_b,
    input  logic [5:0]         idx_c,
    input  logic signed [15:0] pos_x,
    input  logic signed [15:0] pos_y,
    input  logic signed [15:0] pos_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [5:0]         vertex_out,
    output logic signed [15:0] norm_x,
    output logic signed [15:0] norm_y,
    output logic signed [15:0] norm_z,
    output logic               zero_normal
);

    localparam int AW = $clog2(NUM_VERTICES);
    localparam int PW = 3 * vna_pkg::POS_W;
    localparam int SW = 3 * vna_pkg::SUM_W;

    typedef enum logic [14:0] {
        ST_CLEAR   = 15'h0001,
        ST_IDLE    = 15'h0002,
        ST_RDB     = 15'h0004,
        ST_RDC     = 15'h0008,
        ST_EDGE    = 15'h0010,
        ST_CROSS   = 15'h0020,
        ST_LOADM   = 15'h0040,
        ST_SCALE   = 15'h0080,
        ST_SQUARE  = 15'h0100,
        ST_SQRT    = 15'h0200,
        ST_DIVINIT = 15'h0400,
        ST_DIV     = 15'h0800,
        ST_CRD     = 15'h1000,
        ST_CWR     = 15'h2000,
        ST_EMIT    = 15'h4000
    } state_t;

    // control registers
    state_t          state_reg, state_next;
    logic [AW-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [2:0]      k_reg, k_next;
    logic [3:0]      cnt_reg, cnt_next;
    logic [1:0]      corner_reg, corner_next;
    logic            tri_reg, tri_next;
    logic            out_valid_reg, out_valid_next;

    // datapath registers
    logic [5:0]          ia_reg, ia_next, ib_reg, ib_next, ic_reg, ic_next;
    logic [PW-1:0]       pa_reg, pa_next, pb_reg, pb_next;
    logic signed [16:0]  e1_reg [3], e1_next [3], e2_reg [3], e2_next [3];
    logic signed [49:0]  prod_reg, prod_next;
    logic signed [35:0]  cr_reg [3], cr_next [3];
    logic [35:0]         m_reg [3], m_next [3];
    logic                neg_reg [3], neg_next [3];
    logic [35:0]         top_reg, top_next;
    logic [49:0]         sq_reg, sq_next;
    logic [49:0]         v_reg, v_next, res_reg, res_next, bit_reg, bit_next;
    logic [24:0]         rem_reg [3], rem_next [3];
    logic [15:0]         nsh_reg [3], nsh_next [3];
    logic [15:0]         q_reg [3], q_next [3];
    logic                zflag_reg, zflag_next;
    logic [5:0]          vout_reg, vout_next;
    logic signed [15:0]  nx_reg, nx_next, ny_reg, ny_next, nz_reg, nz_next;
    logic                zero_reg, zero_next;

    // memory ports
    logic          pos_we, sum_we;
    logic [AW-1:0] pos_waddr, pos_raddr, sum_waddr, sum_raddr;
    logic [PW-1:0] pos_wdata, pos_rdata;
    logic [SW-1:0] sum_wdata, sum_rdata;

    // shared multiplier operands
    logic signed [24:0] mul_a, mul_b;

    // misc combinational values
    logic               accept;
    logic               a_ok, b_ok, c_ok;
    logic [AW-1:0]      corner_addr;
    logic signed [15:0] n_val [3];
    logic [15:0]        q_clamp [3];
    logic signed [35:0] src [3];
    logic [35:0]        mag [3];
    logic [35:0]        top_ab;
    logic [50:0]        sqrt_t;
    logic [24:0]        len;
    logic [38:0]        num [3];
    logic [25:0]        div_t [3];
    logic signed [24:0] sat_r [3];
    logic signed [23:0] sat_s [3];

    vna_ram #(.WIDTH(PW), .DEPTH(NUM_VERTICES)) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    vna_ram #(.WIDTH(SW), .DEPTH(NUM_VERTICES)) u_sum_ram (
        .clk   (clk),
        .we    (sum_we),
        .waddr (sum_waddr),
        .wdata (sum_wdata),
        .raddr (sum_raddr),
        .rdata (sum_rdata)
    );

    assign in_ready    = (state_reg == ST_IDLE);
    assign accept      = in_valid && in_ready;
    assign a_ok        = 32'(idx_a) < NUM_VERTICES;
    assign b_ok        = 32'(idx_b) < NUM_VERTICES;
    assign c_ok        = 32'(idx_c) < NUM_VERTICES;
    assign len         = res_reg[24:0];
    assign out_valid   = out_valid_reg;
    assign vertex_out  = vout_reg;
    assign norm_x      = nx_reg;
    assign norm_y      = ny_reg;
    assign norm_z      = nz_reg;
    assign zero_normal = zero_reg;

    // corner address for the sum update loop
    always_comb
    begin
        unique case (corner_reg)
            2'd0:    corner_addr = AW'(ia_reg);
            2'd1:    corner_addr = AW'(ib_reg);
            2'd2:    corner_addr = AW'(ic_reg);
            default: corner_addr = AW'(ia_reg);
        endcase
    end

    // clamped, signed quotient lanes
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            q_clamp[l] = (q_reg[l] > vna_pkg::ONE_Q14) ? vna_pkg::ONE_Q14 : q_reg[l];
            n_val[l]   = neg_reg[l] ? -$signed(q_clamp[l]) : $signed(q_clamp[l]);
        end
    end

    // magnitude capture sources and their maximum
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            sat_s[l] = $signed(sum_rdata[24*l +: 24]);
            src[l]   = tri_reg ? cr_reg[l] : 36'(sat_s[l]);
            mag[l]   = src[l][35] ? 36'(-src[l]) : 36'(src[l]);
            sat_r[l] = 25'(sat_s[l]) + 25'(n_val[l]);
        end
        top_ab = (mag[0] > mag[1]) ? mag[0] : mag[1];
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == ST_CROSS)
        begin
            unique case (k_reg)
                3'd0:    begin mul_a = 25'(e1_reg[1]); mul_b = 25'(e2_reg[2]); end
                3'd1:    begin mul_a = 25'(e1_reg[2]); mul_b = 25'(e2_reg[1]); end
                3'd2:    begin mul_a = 25'(e1_reg[2]); mul_b = 25'(e2_reg[0]); end
                3'd3:    begin mul_a = 25'(e1_reg[0]); mul_b = 25'(e2_reg[2]); end
                3'd4:    begin mul_a = 25'(e1_reg[0]); mul_b = 25'(e2_reg[1]); end
                3'd5:    begin mul_a = 25'(e1_reg[1]); mul_b = 25'(e2_reg[0]); end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end
        else if (state_reg == ST_SQUARE)
        begin
            unique case (k_reg)
                3'd0:    mul_a = $signed({1'b0, m_reg[0][23:0]});
                3'd1:    mul_a = $signed({1'b0, m_reg[1][23:0]});
                3'd2:    mul_a = $signed({1'b0, m_reg[2][23:0]});
                default: mul_a = '0;
            endcase
            mul_b = mul_a;
        end
    end

    assign sqrt_t = 51'(res_reg) + 51'(bit_reg);

    // divider numerators and trial subtracts
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            num[l]   = {1'b0, m_reg[l][23:0], 14'd0} + 39'(len >> 1);
            div_t[l] = {rem_reg[l], nsh_reg[l][15]};
        end
    end

    // sequencer and datapath next state
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        k_next         = k_reg;
        cnt_next       = cnt_reg;
        corner_next    = corner_reg;
        tri_next       = tri_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ia_next        = ia_reg;
        ib_next        = ib_reg;
        ic_next        = ic_reg;
        pa_next        = pa_reg;
        pb_next        = pb_reg;
        e1_next        = e1_reg;
        e2_next        = e2_reg;
        prod_next      = mul_a * mul_b;
        cr_next        = cr_reg;
        m_next         = m_reg;
        neg_next       = neg_reg;
        top_next       = top_reg;
        sq_next        = sq_reg;
        v_next         = v_reg;
        res_next       = res_reg;
        bit_next       = bit_reg;
        rem_next       = rem_reg;
        nsh_next       = nsh_reg;
        q_next         = q_reg;
        zflag_next     = zflag_reg;
        vout_next      = vout_reg;
        nx_next        = nx_reg;
        ny_next        = ny_reg;
        nz_next        = nz_reg;
        zero_next      = zero_reg;

        pos_we    = 1'b0;
        pos_waddr = AW'(idx_a);
        pos_wdata = {pos_z, pos_y, pos_x};
        pos_raddr = AW'(idx_a);
        sum_we    = 1'b0;
        sum_waddr = AW'(idx_a);
        sum_wdata = '0;
        sum_raddr = AW'(idx_a);

        unique case (state_reg)
            // zero the sum memory after reset
            ST_CLEAR:
            begin
                sum_we    = 1'b1;
                sum_waddr = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(NUM_VERTICES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            // take a request and start its memory reads
            ST_IDLE:
            begin
                if (accept && a_ok)
                begin
                    ia_next = idx_a;
                    ib_next = idx_b;
                    ic_next = idx_c;
                    if (op == vna_pkg::OP_LOAD)
                    begin
                        pos_we = 1'b1;
                        sum_we = 1'b1;
                    end
                    else if (op == vna_pkg::OP_TRI && b_ok && c_ok)
                    begin
                        tri_next   = 1'b1;
                        state_next = ST_RDB;
                    end
                    else if (op == vna_pkg::OP_READ)
                    begin
                        tri_next   = 1'b0;
                        state_next = ST_LOADM;
                    end
                end
            end

            ST_RDB:
            begin
                pa_next    = pos_rdata;
                pos_raddr  = AW'(ib_reg);
                state_next = ST_RDC;
            end

            ST_RDC:
            begin
                pb_next    = pos_rdata;
                pos_raddr  = AW'(ic_reg);
                state_next = ST_EDGE;
            end

            // edge vectors from the first corner
            ST_EDGE:
            begin
                for (int l = 0; l < 3; l++)
                begin
                    e1_next[l] = 17'($signed(pb_reg[16*l +: 16]))
                               - 17'($signed(pa_reg[16*l +: 16]));
                    e2_next[l] = 17'($signed(pos_rdata[16*l +: 16]))
                               - 17'($signed(pa_reg[16*l +: 16]));
                end
                k_next     = 3'd0;
                state_next = ST_CROSS;
            end

            // cross product, two products per component
            ST_CROSS:
            begin
                for (int l = 0; l < 3; l++)
                begin
                    if (k_reg == 3'(2 * l + 1))
                    begin
                        cr_next[l] = 36'(prod_reg);
                    end
                    if (k_reg == 3'(2 * l + 2))
                    begin
                        cr_next[l] = cr_reg[l] - 36'(prod_reg);
                    end
                end
                k_next = k_reg + 3'd1;
                if (k_reg == 3'd6)
                begin
                    state_next = ST_LOADM;
                end
            end

            // magnitudes, signs and the largest magnitude
            ST_LOADM:
            begin
                for (int l = 0; l < 3; l++)
                begin
                    m_next[l]   = mag[l];
                    neg_next[l] = src[l][35];
                end
                top_next   = (top_ab > mag[2]) ? top_ab : mag[2];
                state_next = ST_SCALE;
            end

            // bring the largest magnitude into [2^23, 2^24), or flag a zero vector
            ST_SCALE:
            begin
                priority if (top_reg == '0)
                begin
                    zflag_next = 1'b1;
                    for (int l = 0; l < 3; l++)
                    begin
                        q_next[l] = '0;
                    end
                    state_next = tri_reg ? ST_IDLE : ST_EMIT;
                end
                else if (top_reg[35:32] != '0)
                begin
                    for (int l = 0; l < 3; l++)
                    begin
                        m_next[l] = m_reg[l] >> 8;
                    end
                    top_next = top_reg >> 8;
                end
                else if (top_reg[35:24] != '0)
                begin
                    for (int l = 0; l < 3; l++)
                    begin
                        m_next[l] = m_reg[l] >> 1;
                    end
                    top_next = top_reg >> 1;
                end
                else if (top_reg[23:15] == '0)
                begin
                    for (int l = 0; l < 3; l++)
                    begin
                        m_next[l] = m_reg[l] << 8;
                    end
                    top_next = top_reg << 8;
                end
                else if (!top_reg[23])
                begin
                    for (int l = 0; l < 3; l++)
                    begin
                        m_next[l] = m_reg[l] << 1;
                    end
                    top_next = top_reg << 1;
                end
                else
                begin
                    k_next     = 3'd0;
                    state_next = ST_SQUARE;
                end
            end

            // sum of squares
            ST_SQUARE:
            begin
                k_next = k_reg + 3'd1;
                if (k_reg == 3'd1)
                begin
                    sq_next = 50'(prod_reg);
                end
                else if (k_reg == 3'd2)
                begin
                    sq_next = sq_reg + 50'(prod_reg);
                end
                else if (k_reg == 3'd3)
                begin
                    v_next     = sq_reg + 50'(prod_reg);
                    res_next   = '0;
                    bit_next   = 50'(1) << 48;
                    state_next = ST_SQRT;
                end
            end

            // bit-serial floor square root
            ST_SQRT:
            begin
                if (51'(v_reg) >= sqrt_t)
                begin
                    v_next   = v_reg - 50'(sqrt_t);
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg[0])
                begin
                    state_next = ST_DIVINIT;
                end
            end

            // rounded numerators into the dividers
            ST_DIVINIT:
            begin
                for (int l = 0; l < 3; l++)
                begin
                    rem_next[l] = 25'(num[l][38:16]);
                    nsh_next[l] = num[l][15:0];
                    q_next[l]   = '0;
                end
                zflag_next = 1'b0;
                cnt_next   = '0;
                state_next = ST_DIV;
            end

            // three restoring dividers, one quotient bit a cycle
            ST_DIV:
            begin
                for (int l = 0; l < 3; l++)
                begin
                    if (div_t[l] >= {1'b0, len})
                    begin
                        rem_next[l] = 25'(div_t[l] - {1'b0, len});
                        q_next[l]   = {q_reg[l][14:0], 1'b1};
                    end
                    else
                    begin
                        rem_next[l] = div_t[l][24:0];
                        q_next[l]   = {q_reg[l][14:0], 1'b0};
                    end
                    nsh_next[l] = nsh_reg[l] << 1;
                end
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    corner_next = 2'd0;
                    state_next  = tri_reg ? ST_CRD : ST_EMIT;
                end
            end

            ST_CRD:
            begin
                sum_raddr  = corner_addr;
                state_next = ST_CWR;
            end

            // saturating add into one corner's sum
            ST_CWR:
            begin
                sum_we    = 1'b1;
                sum_waddr = corner_addr;
                for (int l = 0; l < 3; l++)
                begin
                    priority if (sat_r[l] > vna_pkg::SUM_MAX)
                    begin
                        sum_wdata[24*l +: 24] = 24'(vna_pkg::SUM_MAX);
                    end
                    else if (sat_r[l] < vna_pkg::SUM_MIN)
                    begin
                        sum_wdata[24*l +: 24] = 24'(vna_pkg::SUM_MIN);
                    end
                    else
                    begin
                        sum_wdata[24*l +: 24] = 24'(sat_r[l]);
                    end
                end
                corner_next = corner_reg + 2'd1;
                state_next  = (corner_reg == 2'd2) ? ST_IDLE : ST_CRD;
            end

            // hand the normal to the output register
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    vout_next      = ia_reg;
                    nx_next        = n_val[0];
                    ny_next        = n_val[1];
                    nz_next        = n_val[2];
                    zero_next      = zflag_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            k_reg         <= '0;
            cnt_reg       <= '0;
            corner_reg    <= '0;
            tri_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            k_reg         <= k_next;
            cnt_reg       <= cnt_next;
            corner_reg    <= corner_next;
            tri_reg       <= tri_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath state
    always_ff @(posedge clk)
    begin
        ia_reg    <= ia_next;
        ib_reg    <= ib_next;
        ic_reg    <= ic_next;
        pa_reg    <= pa_next;
        pb_reg    <= pb_next;
        e1_reg    <= e1_next;
        e2_reg    <= e2_next;
        prod_reg  <= prod_next;
        cr_reg    <= cr_next;
        m_reg     <= m_next;
        neg_reg   <= neg_next;
        top_reg   <= top_next;
        sq_reg    <= sq_next;
        v_reg     <= v_next;
        res_reg   <= res_next;
        bit_reg   <= bit_next;
        rem_reg   <= rem_next;
        nsh_reg   <= nsh_next;
        q_reg     <= q_next;
        zflag_reg <= zflag_next;
        vout_reg  <= vout_next;
        nx_reg    <= nx_next;
        ny_reg    <= ny_next;
        nz_reg    <= nz_next;
        zero_reg  <= zero_next;
    end

    // checks
    `VNA_ASSERT_IMP(a_zero_flag_norms, out_valid && zero_normal, norm_x == 16'sd0 && norm_y == 16'sd0 && norm_z == 16'sd0)
    `VNA_ASSERT_IMP(a_scaled_top, state_reg == ST_SQUARE, top_reg[35:24] == '0 && top_reg[23])
    `VNA_ASSERT_IMP(a_div_rem_below_len, state_reg == ST_DIV, rem_reg[0] < len && rem_reg[1] < len && rem_reg[2] < len)
    `VNA_ASSERT_NXT(a_clear_done, state_reg == ST_CLEAR && clr_cnt_reg == AW'(NUM_VERTICES - 1), state_reg == ST_IDLE)

endmodule

>>> tb/vertex_normal_averager_checker.sv
`timescale 1ns / 100ps

module vertex_normal_averager_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [1:0]         op,
    input  logic [5:0]         idx_a,
    input  logic [5:0]         idx_b,
    input  logic [5:0]         idx_c,
    input  logic signed [15:0] pos_x,
    input  logic signed [15:0] pos_y,
    input  logic signed [15:0] pos_z,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [5:0]         vertex_out,
    input  logic signed [15:0] norm_x,
    input  logic signed [15:0] norm_y,
    input  logic signed [15:0] norm_z,
    input  logic               zero_normal,
    output int                 pending,
    output int                 errors
);

    localparam int SUM_HI = 8388607;
    localparam int SUM_LO = -8388608;

    typedef struct {
        logic [5:0]         vertex;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic               zero_flag;
    } normal_t;

    normal_t normal_q[$];
    int      mesh_pos[64][3];
    int      acc_x[64];
    int      acc_y[64];
    int      acc_z[64];
    int      exp_cnt = 0;
    int      err_cnt = 0;

    assign pending = exp_cnt;
    assign errors  = err_cnt;

    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // scale to unit length in Q1.14; returns 0 for a zero vector
    function automatic bit unit_normal(input longint c0, input longint c1, input longint c2,
                                       output int n0, output int n1, output int n2);
        longint          cv[3];
        longint unsigned m[3];
        longint unsigned top;
        longint unsigned len;
        longint unsigned q;
        int              n[3];
        cv[0] = c0;
        cv[1] = c1;
        cv[2] = c2;
        top = 0;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = (cv[i] < 0) ? longint'(-cv[i]) : longint'(cv[i]);
            if (m[i] > top)
                top = m[i];
            n[i] = 0;
        end
        n0 = 0;
        n1 = 0;
        n2 = 0;
        if (top == 0)
            return 1'b0;
        while (top >= (64'd1 << 24))
        begin
            for (int i = 0; i < 3; i++)
                m[i] = m[i] >> 1;
            top = top >> 1;
        end
        while (top < (64'd1 << 23))
        begin
            for (int i = 0; i < 3; i++)
                m[i] = m[i] << 1;
            top = top << 1;
        end
        len = floor_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
        for (int i = 0; i < 3; i++)
        begin
            q = ((m[i] << 14) + (len >> 1)) / len;
            if (q > 16384)
                q = 16384;
            n[i] = (cv[i] < 0) ? -int'(q) : int'(q);
        end
        n0 = n[0];
        n1 = n[1];
        n2 = n[2];
        return 1'b1;
    endfunction

    function automatic int clamp_add(input int s, input int d);
        int r;
        r = s + d;
        if (r > SUM_HI)
            r = SUM_HI;
        if (r < SUM_LO)
            r = SUM_LO;
        return r;
    endfunction

    // compare each accepted result, then predict on each accepted request
    always @(posedge clk or negedge rst_n)
    begin
        longint  e1[3];
        longint  e2[3];
        longint  cr[3];
        int      n0, n1, n2;
        int      a, b, c;
        bit      nonzero;
        normal_t exp_n;
        if (!rst_n)
        begin
            for (int v = 0; v < 64; v++)
            begin
                acc_x[v] = 0;
                acc_y[v] = 0;
                acc_z[v] = 0;
            end
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (normal_q.size() == 0)
                begin
                    $error("unexpected result for vertex %0d", vertex_out);
                    err_cnt++;
                end
                else
                begin
                    exp_n = normal_q.pop_front();
                    exp_cnt--;
                    if (vertex_out !== exp_n.vertex)
                    begin
                        $error("vertex_out expected %0d actual %0d", exp_n.vertex, vertex_out);
                        err_cnt++;
                    end
                    if (norm_x !== exp_n.nx)
                    begin
                        $error("norm_x expected %0d actual %0d", exp_n.nx, norm_x);
                        err_cnt++;
                    end
                    if (norm_y !== exp_n.ny)
                    begin
                        $error("norm_y expected %0d actual %0d", exp_n.ny, norm_y);
                        err_cnt++;
                    end
                    if (norm_z !== exp_n.nz)
                    begin
                        $error("norm_z expected %0d actual %0d", exp_n.nz, norm_z);
                        err_cnt++;
                    end
                    if (zero_normal !== exp_n.zero_flag)
                    begin
                        $error("zero_normal expected %0d actual %0d", exp_n.zero_flag,
                               zero_normal);
                        err_cnt++;
                    end
                end
            end

            if (in_valid && in_ready)
            begin
                a = idx_a;
                b = idx_b;
                c = idx_c;
                if (op == vna_pkg::OP_LOAD)
                begin
                    mesh_pos[a][0] = pos_x;
                    mesh_pos[a][1] = pos_y;
                    mesh_pos[a][2] = pos_z;
                    acc_x[a] = 0;
                    acc_y[a] = 0;
                    acc_z[a] = 0;
                end
                else if (op == vna_pkg::OP_TRI)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        e1[i] = longint'(mesh_pos[b][i]) - mesh_pos[a][i];
                        e2[i] = longint'(mesh_pos[c][i]) - mesh_pos[a][i];
                    end
                    cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
                    cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
                    cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
                    if (unit_normal(cr[0], cr[1], cr[2], n0, n1, n2))
                    begin
                        acc_x[a] = clamp_add(acc_x[a], n0);
                        acc_y[a] = clamp_add(acc_y[a], n1);
                        acc_z[a] = clamp_add(acc_z[a], n2);
                        acc_x[b] = clamp_add(acc_x[b], n0);
                        acc_y[b] = clamp_add(acc_y[b], n1);
                        acc_z[b] = clamp_add(acc_z[b], n2);
                        acc_x[c] = clamp_add(acc_x[c], n0);
                        acc_y[c] = clamp_add(acc_y[c], n1);
                        acc_z[c] = clamp_add(acc_z[c], n2);
                    end
                end
                else if (op == vna_pkg::OP_READ)
                begin
                    nonzero = unit_normal(acc_x[a], acc_y[a], acc_z[a], n0, n1, n2);
                    exp_n.vertex    = idx_a;
                    exp_n.nx        = n0[15:0];
                    exp_n.ny        = n1[15:0];
                    exp_n.nz        = n2[15:0];
                    exp_n.zero_flag = !nonzero;
                    normal_q.insert(normal_q.size(), exp_n);
                    exp_cnt++;
                end
            end
        end
    end

endmodule

>>> tb/vertex_normal_averager_tb.sv
`timescale 1ns / 100ps

module vertex_normal_averager_tb;

    localparam int STALL_LIMIT = 5000;
    localparam logic [1:0] OP_NONE = 2'd3;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         op = vna_pkg::OP_LOAD;
    logic [5:0]         idx_a = '0;
    logic [5:0]         idx_b = '0;
    logic [5:0]         idx_c = '0;
    logic signed [15:0] pos_x = '0;
    logic signed [15:0] pos_y = '0;
    logic signed [15:0] pos_z = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [5:0]         vertex_out;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic               zero_normal;

    int pending;
    int errors;
    bit calm = 1'b0;
    bit loaded[64];
    int quiet_cycles = 0;

    vertex_normal_averager dut (.*);

    vertex_normal_averager_checker checker_i (.*);

    initial
    begin
        forever
            #4 clk = ~clk;
    end

    // result side back-pressure
    always @(negedge clk)
        out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 31);

    // watchdog on lack of progress
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_req(input logic [1:0] o, input int a, input int b, input int c,
                            input int x, input int y, input int z);
        if (!calm && $urandom_range(99) < 31)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge clk);
        end
        op       <= o;
        idx_a    <= 6'(a);
        idx_b    <= 6'(b);
        idx_c    <= 6'(c);
        pos_x    <= 16'(x);
        pos_y    <= 16'(y);
        pos_z    <= 16'(z);
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        if (o == vna_pkg::OP_LOAD)
            loaded[a] = 1'b1;
    endtask

    task automatic load_vertex(input int a, input int x, input int y, input int z);
        send_req(vna_pkg::OP_LOAD, a, $urandom_range(63), $urandom_range(63), x, y, z);
    endtask

    task automatic add_tri(input int a, input int b, input int c);
        send_req(vna_pkg::OP_TRI, a, b, c, $urandom, $urandom, $urandom);
    endtask

    task automatic read_normal(input int a);
        send_req(vna_pkg::OP_READ, a, $urandom_range(63), $urandom_range(63),
                 $urandom, $urandom, $urandom);
    endtask

    function automatic int pick_loaded();
        int v;
        v = $urandom_range(63);
        while (!loaded[v])
            v = $urandom_range(63);
        return v;
    endfunction

    function automatic int rand_coord();
        int k;
        k = $urandom_range(9);
        if (k < 4)
            return $signed(16'($urandom));
        if (k < 6)
            return ($urandom_range(1) != 0) ? 32767 : -32768;
        return $urandom_range(2048) - 1024;
    endfunction

    initial
    begin
        int k;
        int a;
        int b;
        int c;
        for (int v = 0; v < 64; v++)
            loaded[v] = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: extreme coordinates, degenerate and repeated-corner triangles
        load_vertex(0, -32768, -32768, -32768);
        load_vertex(1, 32767, -32768, 32767);
        load_vertex(2, 32767, 32767, -32768);
        load_vertex(3, 0, 0, 0);
        load_vertex(4, 256, 0, 0);
        load_vertex(5, 0, 256, 0);
        load_vertex(6, 512, 0, 0);
        load_vertex(63, 32767, 32767, 32767);
        add_tri(0, 1, 2);
        add_tri(3, 4, 5);
        add_tri(3, 3, 4);
        add_tri(3, 4, 6);
        add_tri(63, 0, 1);
        send_req(OP_NONE, 63, 63, 63, -1, -1, -1);
        read_normal(0);
        read_normal(1);
        read_normal(3);
        read_normal(4);
        read_normal(6);
        read_normal(7);
        read_normal(63);
        load_vertex(3, 100, -100, 100);
        read_normal(3);

        // hold off until every predicted normal has come back
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);

        // random mesh traffic, with a stretch without idling
        for (int i = 0; i < 300; i++)
        begin
            calm = (i >= 120 && i < 180);
            k = $urandom_range(99);
            if (k < 20)
                load_vertex($urandom_range(63), rand_coord(), rand_coord(), rand_coord());
            else if (k < 65)
            begin
                a = pick_loaded();
                b = pick_loaded();
                c = ($urandom_range(9) == 0) ? a : pick_loaded();
                add_tri(a, b, c);
            end
            else if (k < 95)
                read_normal($urandom_range(63));
            else
                send_req(OP_NONE, $urandom_range(63), $urandom_range(63), $urandom_range(63),
                         $urandom, $urandom, $urandom);
        end
        calm = 1'b0;

        // pile up one face normal until the sums saturate
        load_vertex(60, 0, 0, 0);
        load_vertex(61, 256, 0, 0);
        load_vertex(62, 0, 256, 0);
        for (int i = 0; i < 540; i++)
        begin
            add_tri(60, 61, 62);
            if (i % 40 == 0)
                read_normal(60 + $urandom_range(2));
        end
        read_normal(60);
        read_normal(61);
        read_normal(62);

        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
